// File: rtl/scm_pkg.sv
// Shared types and constants of the sparse COO MTTKRP engine.
// No dependencies; every other file of the block but scm_bank imports this package.
package scm_pkg;

    localparam int NUM_FACTORS = 3;
    localparam int RANK_W      = 6;
    localparam int ROW_W       = 10;
    localparam int COL_W       = 5;
    localparam int WORD_W      = 32;
    localparam int CFG_IDX_W   = 2;

    // Request types.
    localparam logic [1:0] REQ_WRITE   = 2'd0;
    localparam logic [1:0] REQ_READ    = 2'd1;
    localparam logic [1:0] REQ_NONZERO = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_RANK        = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OUTPUT_MODE = 2'd1;

    localparam logic [RANK_W-1:0] RANK_RESET = 6'd16;
    localparam logic [1:0]        MODE_RESET = 2'd0;

    typedef struct packed {
        logic [1:0]               req_type;
        logic [1:0]               factor_sel;
        logic [ROW_W-1:0]         factor_row;
        logic [COL_W-1:0]         factor_col;
        logic signed [WORD_W-1:0] factor_data;
        logic [ROW_W-1:0]         index_mode0;
        logic [ROW_W-1:0]         index_mode1;
        logic [ROW_W-1:0]         index_mode2;
        logic signed [WORD_W-1:0] tensor_value;
    } in_item_t;

    typedef struct packed {
        logic signed [WORD_W-1:0] read_data;
        logic                     saturated;
    } out_item_t;

    // Controller to datapath.
    typedef struct packed {
        logic load;   // latch the accepted request
        logic write;  // write the latched factor entry
        logic read;   // start a factor entry read
        logic issue;  // issue one rank column of a nonzero
    } cmd_t;

    // Datapath to controller.
    typedef struct packed {
        logic write_ok;
        logic is_read;
        logic nz_ok;
        logic last_col;
        logic pipe_busy;
        logic read_busy;
    } stat_t;

endpackage

// File: rtl/scm_bank.sv
// One factor matrix store: one write port and one read port with registered read data.
// No dependencies.
module scm_bank #(
    parameter int DEPTH = 32768,
    parameter int AW    = 15,
    parameter int WIDTH = 32
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// File: rtl/scm_ctrl.sv
// Request sequencer of the MTTKRP engine: accepts requests and steps the datapath.
// Depends on scm_pkg for the command and status structs.
module scm_ctrl import scm_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       item_valid,
    input  logic [1:0] item_req_type,
    output logic       item_stall,
    input  stat_t      stat,
    output cmd_t       cmd
);

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_DECODE = 4'b0010,
        ST_RUN    = 4'b0100,
        ST_DRAIN  = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   accept;

    // A read waits until the previous read result has left the output register.
    assign item_stall = (state_reg != ST_IDLE) ||
                        ((item_req_type == REQ_READ) && stat.read_busy);
    assign accept = item_valid && !item_stall;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                if (stat.write_ok)
                begin
                    cmd.write  = 1'b1;
                    state_next = ST_IDLE;
                end
                else if (stat.is_read)
                begin
                    cmd.read   = 1'b1;
                    state_next = ST_IDLE;
                end
                else if (stat.nz_ok)
                begin
                    state_next = ST_RUN;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_RUN:
            begin
                cmd.issue = 1'b1;
                if (stat.last_col)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (!stat.pipe_busy)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// File: rtl/scm_datapath.sv
// Datapath of the MTTKRP engine: configuration registers, the three factor banks,
// the multiply pipeline, saturation and the output register. Uses scm_pkg and scm_bank.
module scm_datapath import scm_pkg::*; #(
    parameter int MAX_RANK = 32,
    parameter int ROWS     = 1024
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_valid,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [RANK_W-1:0]    cfg_data,
    input  in_item_t             item,
    input  cmd_t                 cmd,
    output stat_t                stat,
    output logic                 result_valid,
    input  logic                 result_stall,
    output out_item_t            result
);

    localparam int DEPTH = ROWS * MAX_RANK;
    localparam int AW    = $clog2(DEPTH);

    localparam logic signed [64:0] SUM_MAX = 65'sd2147483647;
    localparam logic signed [64:0] SUM_MIN = -65'sd2147483648;

    // Configuration and latched request.
    logic [RANK_W-1:0] rank_reg;
    logic [1:0]        mode_reg;
    in_item_t          item_reg;
    logic [RANK_W-1:0] col_reg;

    // Product pipeline.
    logic                     s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg;
    logic [AW-1:0]            s1_addr_reg, s2_addr_reg, s3_addr_reg, s4_addr_reg;
    logic signed [63:0]       s2_prod_reg;
    logic signed [WORD_W-1:0] s2_b_reg, s2_d_reg, s3_d_reg, s4_d_reg;
    logic signed [63:0]       s3_hi_reg;
    logic signed [64:0]       s3_lo_reg;
    logic signed [63:0]       s4_t_reg;
    logic                     sat_reg;

    // Read path.
    logic      rd_pending_reg;
    logic      out_valid_reg;
    out_item_t out_item_reg;

    logic [RANK_W-1:0]        eff_rank;
    logic                     entry_ok;
    logic [AW-1:0]            entry_addr;
    logic [ROW_W-1:0]         idx [NUM_FACTORS];
    logic [AW-1:0]            nz_addr [NUM_FACTORS];
    logic [WORD_W-1:0]        bank_rdata [NUM_FACTORS];
    logic [1:0]               mode_a, mode_b;
    logic signed [WORD_W-1:0] op_v, op_a, op_b, op_d;
    logic signed [63:0]       prod_next;
    logic signed [31:0]       prod_hi;
    logic signed [32:0]       prod_lo;
    logic signed [63:0]       hi_next;
    logic signed [64:0]       lo_next;
    logic signed [32:0]       lo_shift;
    logic signed [64:0]       sum_wide;
    logic                     sat_hi, sat_lo;
    logic [WORD_W-1:0]        wb_data;
    logic [WORD_W-1:0]        rd_word;

    assign eff_rank = (32'(rank_reg) > MAX_RANK) ? RANK_W'(MAX_RANK) : rank_reg;

    assign entry_ok = (32'(item_reg.factor_sel) < NUM_FACTORS) &&
                      (32'(item_reg.factor_row) < ROWS) &&
                      (32'(item_reg.factor_col) < MAX_RANK);
    assign entry_addr = AW'(32'(item_reg.factor_row) * MAX_RANK +
                            32'(item_reg.factor_col));

    assign idx[0] = item_reg.index_mode0;
    assign idx[1] = item_reg.index_mode1;
    assign idx[2] = item_reg.index_mode2;

    // The two modes other than the output mode supply the operands.
    assign mode_a = (mode_reg == 2'd0) ? 2'd1 : 2'd0;
    assign mode_b = (mode_reg == 2'd2) ? 2'd1 : 2'd2;

    assign stat.write_ok  = (item_reg.req_type == REQ_WRITE) && entry_ok;
    assign stat.is_read   = (item_reg.req_type == REQ_READ);
    assign stat.nz_ok     = (item_reg.req_type == REQ_NONZERO) &&
                            (32'(mode_reg) < NUM_FACTORS) &&
                            (32'(idx[0]) < ROWS) && (32'(idx[1]) < ROWS) &&
                            (32'(idx[2]) < ROWS) && (eff_rank != '0);
    assign stat.last_col  = (col_reg == eff_rank - RANK_W'(1));
    assign stat.pipe_busy = s1_valid_reg || s2_valid_reg || s3_valid_reg || s4_valid_reg;
    assign stat.read_busy = rd_pending_reg || out_valid_reg;

    // Saturating accumulate of the shifted triple product.
    assign sum_wide = 65'(s4_d_reg) + 65'(s4_t_reg);
    assign sat_hi   = (sum_wide > SUM_MAX);
    assign sat_lo   = (sum_wide < SUM_MIN);
    assign wb_data  = sat_hi ? 32'h7FFF_FFFF : (sat_lo ? 32'h8000_0000 : sum_wide[31:0]);

    genvar g;
    generate
        for (g = 0; g < NUM_FACTORS; g++)
        begin : g_bank
            logic          wr_en;
            logic [AW-1:0] wr_addr;
            logic [31:0]   wr_data;
            logic [AW-1:0] rd_addr;

            assign nz_addr[g] = AW'(32'(idx[g]) * MAX_RANK + 32'(col_reg));
            // Item writes and nonzero write-backs never overlap in time.
            assign wr_en   = (cmd.write && (32'(item_reg.factor_sel) == g)) ||
                             (s4_valid_reg && (32'(mode_reg) == g));
            assign wr_addr = s4_valid_reg ? s4_addr_reg : entry_addr;
            assign wr_data = s4_valid_reg ? wb_data : item_reg.factor_data;
            assign rd_addr = cmd.issue ? nz_addr[g] : entry_addr;

            scm_bank #(
                .DEPTH(DEPTH),
                .AW   (AW),
                .WIDTH(WORD_W)
            ) u_bank (
                .clk    (clk),
                .wr_en  (wr_en),
                .wr_addr(wr_addr),
                .wr_data(wr_data),
                .rd_addr(rd_addr),
                .rd_data(bank_rdata[g])
            );
        end
    endgenerate

    assign op_v = item_reg.tensor_value;
    assign op_a = bank_rdata[mode_a];
    assign op_b = bank_rdata[mode_b];
    assign op_d = (32'(mode_reg) < NUM_FACTORS) ? bank_rdata[mode_reg] : '0;

    assign prod_next = op_v * op_a;
    assign prod_hi   = s2_prod_reg[63:32];
    assign prod_lo   = {1'b0, s2_prod_reg[31:0]};
    assign hi_next   = prod_hi * s2_b_reg;
    assign lo_next   = prod_lo * s2_b_reg;
    // Taking the upper bits of the low partial product floors toward minus infinity.
    assign lo_shift  = s3_lo_reg[64:32];

    assign rd_word = (entry_ok && (32'(item_reg.factor_sel) < NUM_FACTORS)) ?
                     bank_rdata[item_reg.factor_sel] : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rank_reg       <= RANK_RESET;
            mode_reg       <= MODE_RESET;
            col_reg        <= '0;
            s1_valid_reg   <= 1'b0;
            s2_valid_reg   <= 1'b0;
            s3_valid_reg   <= 1'b0;
            s4_valid_reg   <= 1'b0;
            sat_reg        <= 1'b0;
            rd_pending_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    CFG_RANK:        rank_reg <= cfg_data;
                    CFG_OUTPUT_MODE: mode_reg <= cfg_data[1:0];
                    default:         ;
                endcase
            end
            if (cmd.load)
            begin
                col_reg <= '0;
            end
            else if (cmd.issue)
            begin
                col_reg <= col_reg + RANK_W'(1);
            end
            s1_valid_reg <= cmd.issue;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
            if (s4_valid_reg && (sat_hi || sat_lo))
            begin
                sat_reg <= 1'b1;
            end
            rd_pending_reg <= cmd.read;
            if (rd_pending_reg)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !result_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            item_reg <= item;
        end
        s1_addr_reg <= nz_addr[mode_reg < 2'd3 ? mode_reg : 2'd0];
        s2_prod_reg <= prod_next;
        s2_b_reg    <= op_b;
        s2_d_reg    <= op_d;
        s2_addr_reg <= s1_addr_reg;
        s3_hi_reg   <= hi_next;
        s3_lo_reg   <= lo_next;
        s3_d_reg    <= s2_d_reg;
        s3_addr_reg <= s2_addr_reg;
        s4_t_reg    <= s3_hi_reg + 64'(lo_shift);
        s4_d_reg    <= s3_d_reg;
        s4_addr_reg <= s3_addr_reg;
        if (rd_pending_reg)
        begin
            out_item_reg.read_data <= rd_word;
            out_item_reg.saturated <= sat_reg;
        end
    end

    assign result_valid = out_valid_reg;
    assign result       = out_item_reg;

endmodule

// File: rtl/sparse_coo_mttkrp.sv
// Three-way sparse MTTKRP engine over a COO request stream, with local factor storage.
// A write updates its factor entry from the decode state; a read takes its entry through
// the bank's read register into the output register. A tensor nonzero issues its rank
// columns, up to its effective rank (the rank capped at MAX_RANK), one per cycle into
// three independent factor banks (one read and one write port each), and a four-stage
// multiply and saturate pipeline then drains before the next request. A nonzero that is
// ignored, or that meets a rank of zero, returns to idle from the decode state like a
// write. Columns of one nonzero touch distinct entries, so they overlap without hazards.
// The factor store is not cleared at reset; reading an entry that was never written
// returns whatever the memory holds. The saturation flag is sticky until reset.
// Depends on scm_pkg, scm_ctrl, scm_datapath and scm_bank.
module sparse_coo_mttkrp import scm_pkg::*; #(
    parameter int MAX_RANK = 32,
    parameter int ROWS     = 1024
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 item_valid,
    output logic                 item_stall,
    input  in_item_t             item,
    output logic                 result_valid,
    input  logic                 result_stall,
    output out_item_t            result,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [RANK_W-1:0]    cfg_data
);

    cmd_t  cmd;
    stat_t stat;

    assign cfg_ready = 1'b1;

    scm_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_req_type(item.req_type),
        .item_stall   (item_stall),
        .stat         (stat),
        .cmd          (cmd)
    );

    scm_datapath #(
        .MAX_RANK(MAX_RANK),
        .ROWS    (ROWS)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .item        (item),
        .cmd         (cmd),
        .stat        (stat),
        .result_valid(result_valid),
        .result_stall(result_stall),
        .result      (result)
    );

endmodule

// File: tb/sv/tb_sparse_coo_mttkrp.sv
// Self-checking testbench for the sparse COO MTTKRP engine: host access, nonzero
// accumulation with floor rounding and saturation, and back-pressure on both channels.
// Depends on scm_pkg and sparse_coo_mttkrp.
module tb_sparse_coo_mttkrp;
    import scm_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int TB_MAX_RANK      = 32;
    localparam int TB_ROWS          = 1024;
    localparam int CLK_HALF         = 5;
    localparam int RESET_CYCLES     = 6;
    localparam int SETTLE_CYCLES    = 48;
    localparam int LONG_HOLD_CYCLES = 400;
    localparam int PHASE_REQUESTS   = 200;
    localparam int TIMEOUT_NS       = 8_000_000;

    // Codes the package leaves unnamed.
    localparam logic [1:0] REQ_UNKNOWN = 2'd3;
    localparam logic [1:0] SEL_NONE    = 2'd3;
    localparam logic [1:0] MODE_NONE   = 2'd3;

    localparam logic signed [95:0] Q_MAX = 96'sd2147483647;
    localparam logic signed [95:0] Q_MIN = -96'sd2147483648;

    logic                 clk          = 1'b0;
    logic                 rst_n        = 1'b0;
    logic                 item_valid   = 1'b0;
    logic                 item_stall;
    in_item_t             item         = '0;
    logic                 result_valid;
    logic                 result_stall = 1'b0;
    out_item_t            result;
    logic                 cfg_valid    = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index    = '0;
    logic [RANK_W-1:0]    cfg_data     = '0;

    // Shadow of the engine: factor store, registers and sticky flag.
    logic signed [WORD_W-1:0] factor_mem [int];
    int                       written_addrs [$];
    logic [RANK_W-1:0]        rank_cfg;
    logic [1:0]               mode_cfg;
    logic                     sat_flag;
    out_item_t                expected_reads [$];

    logic [ROW_W-1:0] row_pool [4];
    logic             idle_on = 1'b1;
    int               hold_requests = 0;
    int               hold_served   = 0;
    int               requests_sent = 0;
    int               noise_sent    = 0;
    int               nonzeros_seen = 0;
    int               reads_checked = 0;
    int               settings_applied = 0;
    int               mismatches    = 0;

    sparse_coo_mttkrp #(
        .MAX_RANK(TB_MAX_RANK),
        .ROWS    (TB_ROWS)
    ) DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .item_valid  (item_valid),
        .item_stall  (item_stall),
        .item        (item),
        .result_valid(result_valid),
        .result_stall(result_stall),
        .result      (result),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    always #CLK_HALF clk = ~clk;

    function automatic int entry_addr(input int sel, input int row, input int col);
        return (sel * TB_ROWS + row) * TB_MAX_RANK + col;
    endfunction

    function automatic void model_request(input in_item_t req);
        out_item_t          answer;
        int                 eff;
        int                 om;
        int                 ma;
        int                 mb;
        int                 a;
        int                 idx [3];
        logic signed [95:0] tv;
        logic signed [95:0] fa;
        logic signed [95:0] fb;
        logic signed [95:0] acc;
        case (req.req_type)
            REQ_WRITE:
            begin
                if (req.factor_sel != SEL_NONE)
                begin
                    a = entry_addr(req.factor_sel, req.factor_row, req.factor_col);
                    if (!factor_mem.exists(a))
                        written_addrs.push_back(a);
                    factor_mem[a] = req.factor_data;
                end
            end
            REQ_READ:
            begin
                answer.read_data = '0;
                if (req.factor_sel != SEL_NONE)
                    answer.read_data =
                        factor_mem[entry_addr(req.factor_sel, req.factor_row, req.factor_col)];
                answer.saturated = sat_flag;
                expected_reads.push_back(answer);
            end
            REQ_NONZERO:
            begin
                if (mode_cfg != MODE_NONE)
                begin
                    nonzeros_seen++;
                    om = mode_cfg;
                    ma = (om == 0) ? 1 : 0;
                    mb = (om == 2) ? 1 : 2;
                    idx[0] = req.index_mode0;
                    idx[1] = req.index_mode1;
                    idx[2] = req.index_mode2;
                    eff = (rank_cfg > TB_MAX_RANK) ? TB_MAX_RANK : rank_cfg;
                    tv = req.tensor_value;
                    for (int r = 0; r < eff; r++)
                    begin
                        fa  = factor_mem[entry_addr(ma, idx[ma], r)];
                        fb  = factor_mem[entry_addr(mb, idx[mb], r)];
                        acc = factor_mem[entry_addr(om, idx[om], r)];
                        // The triple product is exact at 96 bits; the arithmetic shift floors.
                        acc = acc + ((tv * fa * fb) >>> 32);
                        if (acc > Q_MAX)
                        begin
                            acc = Q_MAX;
                            sat_flag = 1'b1;
                        end
                        else if (acc < Q_MIN)
                        begin
                            acc = Q_MIN;
                            sat_flag = 1'b1;
                        end
                        factor_mem[entry_addr(om, idx[om], r)] = acc[WORD_W-1:0];
                    end
                end
            end
            default: ;
        endcase
    endfunction

    function automatic in_item_t random_fields();
        logic [127:0] bits;
        bits = {$urandom(), $urandom(), $urandom(), $urandom()};
        return in_item_t'(bits[$bits(in_item_t)-1:0]);
    endfunction

    // Mostly values within two units, now and then the full Q16.16 range.
    function automatic logic signed [WORD_W-1:0] sample_word();
        if ($urandom_range(0, 4) == 0)
            return $urandom();
        return $urandom_range(0, 32'h3FFFF) - 32'h20000;
    endfunction

    function automatic int pick_index();
        if ($urandom_range(0, 99) < 97)
            return row_pool[$urandom_range(0, 3)];
        return $urandom_range(0, TB_ROWS - 1);
    endfunction

    task automatic send_request(input in_item_t req);
        if (idle_on && $urandom_range(0, 5) == 0)
        begin
            item_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
        item       <= req;
        item_valid <= 1'b1;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        requests_sent++;
        model_request(req);
    endtask

    task automatic send_entry_request(input logic [1:0] kind, input logic [1:0] sel,
                                      input int row, input int col,
                                      input logic signed [WORD_W-1:0] data);
        in_item_t req;
        req             = random_fields();
        req.req_type    = kind;
        req.factor_sel  = sel;
        req.factor_row  = ROW_W'(row);
        req.factor_col  = COL_W'(col);
        req.factor_data = data;
        send_request(req);
    endtask

    task automatic prepare_entry(input int sel, input int row, input int col);
        if (!factor_mem.exists(entry_addr(sel, row, col)))
            send_entry_request(REQ_WRITE, 2'(sel), row, col, sample_word());
    endtask

    // Every entry that the nonzero reads or updates is written first.
    task automatic send_nonzero(input int i0, input int i1, input int i2,
                                input logic signed [WORD_W-1:0] value);
        in_item_t req;
        int       eff;
        eff = (rank_cfg > TB_MAX_RANK) ? TB_MAX_RANK : rank_cfg;
        if (mode_cfg != MODE_NONE)
            for (int r = 0; r < eff; r++)
            begin
                prepare_entry(0, i0, r);
                prepare_entry(1, i1, r);
                prepare_entry(2, i2, r);
            end
        req              = random_fields();
        req.req_type     = REQ_NONZERO;
        req.index_mode0  = ROW_W'(i0);
        req.index_mode1  = ROW_W'(i1);
        req.index_mode2  = ROW_W'(i2);
        req.tensor_value = value;
        send_request(req);
    endtask

    task automatic read_written_entry();
        int a;
        if (written_addrs.size() == 0)
            return;
        a = written_addrs[$urandom_range(0, written_addrs.size() - 1)];
        send_entry_request(REQ_READ, 2'(a / (TB_ROWS * TB_MAX_RANK)),
                           (a / TB_MAX_RANK) % TB_ROWS, a % TB_MAX_RANK, sample_word());
    endtask

    task automatic drain_results();
        item_valid <= 1'b0;
        while (expected_reads.size() != 0)
            @(posedge clk);
        // Writes and nonzeros give no result, so let the pipeline empty out too.
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_config(input logic [RANK_W-1:0] rank_val, input logic [1:0] mode_val);
        logic [RANK_W-1:0] mode_word;
        mode_word       = RANK_W'($urandom_range(0, 63));
        mode_word[1:0]  = mode_val;
        cfg_index <= CFG_RANK;
        cfg_data  <= rank_val;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        rank_cfg = rank_val;
        cfg_index <= CFG_OUTPUT_MODE;
        cfg_data  <= mode_word;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        mode_cfg = mode_word[1:0];
        cfg_valid <= 1'b0;
        settings_applied++;
    endtask

    task automatic test_host_access();
        send_entry_request(REQ_WRITE, 2'd0, 0, 0, 32'sh7FFFFFFF);
        send_entry_request(REQ_WRITE, 2'd2, TB_ROWS - 1, TB_MAX_RANK - 1, 32'sh80000000);
        send_entry_request(REQ_WRITE, 2'd1, 682, 21, 32'sh00010000);
        send_entry_request(REQ_WRITE, SEL_NONE, 5, 5, 32'sh12345678);
        send_entry_request(REQ_UNKNOWN, 2'd0, 0, 0, 32'sh0);
        send_entry_request(REQ_READ, 2'd0, 0, 0, 32'sh0);
        send_entry_request(REQ_READ, 2'd2, TB_ROWS - 1, TB_MAX_RANK - 1, 32'sh0);
        send_entry_request(REQ_READ, 2'd1, 682, 21, 32'sh0);
        send_entry_request(REQ_READ, SEL_NONE, 5, 5, 32'sh0);
        send_entry_request(REQ_READ, SEL_NONE, TB_ROWS - 1, TB_MAX_RANK - 1, 32'sh0);
    endtask

    task automatic test_column_products();
        drain_results();
        set_config(6'd1, 2'd0);
        send_entry_request(REQ_WRITE, 2'd0, 5, 0, 32'sh0);
        send_entry_request(REQ_WRITE, 2'd1, TB_ROWS - 1, 0, 32'sh00008000);
        send_entry_request(REQ_WRITE, 2'd2, 0, 0, 32'sh00010000);
        // A tiny negative product has to round down to minus one LSB.
        send_nonzero(5, TB_ROWS - 1, 0, -32'sd1);
        send_entry_request(REQ_READ, 2'd0, 5, 0, 32'sh0);
        send_nonzero(0, TB_ROWS - 1, 0, 32'sh7FFFFFFF);
        send_entry_request(REQ_READ, 2'd0, 0, 0, 32'sh0);
        drain_results();
        set_config(6'd1, 2'd1);
        send_nonzero(5, TB_ROWS - 1, 0, 32'sh80000000);
        send_entry_request(REQ_READ, 2'd1, TB_ROWS - 1, 0, 32'sh0);
        drain_results();
        set_config(6'd1, 2'd2);
        send_nonzero(0, TB_ROWS - 1, 0, 32'sh80000000);
        send_entry_request(REQ_READ, 2'd2, 0, 0, 32'sh0);
    endtask

    task automatic test_rank_zero_and_mode_three();
        drain_results();
        set_config(6'd0, 2'd0);
        send_nonzero(5, TB_ROWS - 1, 0, 32'sh7FFFFFFF);
        send_entry_request(REQ_READ, 2'd0, 5, 0, 32'sh0);
        drain_results();
        set_config(6'd1, MODE_NONE);
        send_nonzero(5, TB_ROWS - 1, 0, 32'sh7FFFFFFF);
        send_entry_request(REQ_READ, 2'd1, TB_ROWS - 1, 0, 32'sh0);
    endtask

    task automatic test_result_backpressure();
        drain_results();
        set_config(6'd16, 2'd0);
        idle_on = 1'b0;
        // Results are held off while reads keep coming, so the engine backs up
        // into its request port.
        hold_requests++;
        repeat (40) read_written_entry();
        drain_results();
        idle_on = 1'b1;
    endtask

    task automatic random_request_step();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 35)
            send_nonzero(pick_index(), pick_index(), pick_index(), sample_word());
        else if (pick < 62)
            read_written_entry();
        else if (pick < 66)
            send_entry_request(REQ_READ, SEL_NONE, $urandom_range(0, TB_ROWS - 1),
                               $urandom_range(0, TB_MAX_RANK - 1), sample_word());
        else if (pick < 84)
            send_entry_request(REQ_WRITE, 2'($urandom_range(0, 2)),
                               $urandom_range(0, TB_ROWS - 1),
                               $urandom_range(0, TB_MAX_RANK - 1), sample_word());
        else if (pick < 95)
            send_entry_request(REQ_WRITE, 2'($urandom_range(0, 2)), pick_index(),
                               $urandom_range(0, TB_MAX_RANK - 1), sample_word());
        else
        begin
            noise_sent++;
            if ($urandom_range(0, 1) == 0)
                send_entry_request(REQ_UNKNOWN, 2'($urandom_range(0, 3)),
                                   $urandom_range(0, TB_ROWS - 1),
                                   $urandom_range(0, TB_MAX_RANK - 1), sample_word());
            else
                send_entry_request(REQ_WRITE, SEL_NONE, $urandom_range(0, TB_ROWS - 1),
                                   $urandom_range(0, TB_MAX_RANK - 1), sample_word());
        end
    endtask

    task automatic test_random_mix();
        logic [RANK_W-1:0] ranks [8] = '{6'd16, 6'd3, 6'd32, 6'd63, 6'd0, 6'd33, 6'd2, 6'd5};
        logic [1:0]        modes [8] = '{2'd0, 2'd1, 2'd2, 2'd0, 2'd2, 2'd1, MODE_NONE, 2'd1};
        int                phase_start;
        row_pool[0] = '0;
        row_pool[1] = '1;
        row_pool[2] = ROW_W'($urandom_range(1, TB_ROWS - 2));
        row_pool[3] = ROW_W'($urandom_range(1, TB_ROWS - 2));
        for (int p = 0; p < 8; p++)
        begin
            drain_results();
            set_config(ranks[p], modes[p]);
            if (p == 7)
                idle_on = 1'b0;
            phase_start = requests_sent - noise_sent;
            while (requests_sent - noise_sent - phase_start < PHASE_REQUESTS)
                random_request_step();
        end
    endtask

    // Result-side stall: one long hold on request, otherwise short random bursts while idling is on.
    always @(posedge clk)
    begin : drive_result_stall
        int hold_left;
        int burst_left;
        if (hold_left == 0 && hold_served != hold_requests)
        begin
            hold_served++;
            hold_left = LONG_HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            result_stall <= 1'b1;
        end
        else if (burst_left > 0)
        begin
            burst_left--;
            result_stall <= 1'b1;
        end
        else
        begin
            result_stall <= 1'b0;
            if (idle_on && rst_n && $urandom_range(0, 9) == 0)
                burst_left = $urandom_range(1, 8);
        end
    end

    always @(posedge clk)
    begin : check_results
        out_item_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            if (expected_reads.size() == 0)
            begin
                $error("result with no read outstanding: read_data %h saturated %b",
                       result.read_data, result.saturated);
                mismatches++;
            end
            else
            begin
                want = expected_reads.pop_front();
                reads_checked++;
                if (result.read_data !== want.read_data)
                begin
                    $error("read_data: expected %h, actual %h", want.read_data,
                           result.read_data);
                    mismatches++;
                end
                if (result.saturated !== want.saturated)
                begin
                    $error("saturated: expected %b, actual %b", want.saturated,
                           result.saturated);
                    mismatches++;
                end
            end
        end
    end

    initial
    begin
        rank_cfg = RANK_RESET;
        mode_cfg = MODE_RESET;
        sat_flag = 1'b0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_host_access();
        test_column_products();
        test_rank_zero_and_mode_three();
        test_result_backpressure();
        test_random_mix();
        drain_results();

        if (expected_reads.size() != 0)
        begin
            $error("%0d reads never answered", expected_reads.size());
            mismatches++;
        end
        $display("Sent %0d requests (%0d nonzeros accumulated) over %0d register settings,",
                 requests_sent, nonzeros_seen, settings_applied);
        $display("checked %0d read results, with a long result hold and random idling.",
                 reads_checked);
        if (mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    initial
    begin
        #(TIMEOUT_NS);
        $display("Timeout with %0d reads outstanding", expected_reads.size());
        $display("*** FAILED ***");
        $finish;
    end

endmodule

// File: sparse_coo_mttkrp.f
rtl/scm_pkg.sv
rtl/scm_bank.sv
rtl/scm_ctrl.sv
rtl/scm_datapath.sv
rtl/sparse_coo_mttkrp.sv
tb/sv/tb_sparse_coo_mttkrp.sv
